// ===== rtl/spos_pkg.sv =====
package spos_pkg;

  localparam logic [1:0] FN_APPEND = 2'd0;
  localparam logic [1:0] FN_XLATE  = 2'd1;
  localparam logic [1:0] FN_CLEAR  = 2'd2;
  localparam logic [1:0] FN_NONE   = 2'd3;

  localparam logic [1:0] ST_XLATED = 2'd0;
  localparam logic [1:0] ST_DONE   = 2'd1;
  localparam logic [1:0] ST_RANGE  = 2'd2;
  localparam logic [1:0] ST_FULL   = 2'd3;

  typedef struct packed {
    logic [1:0]  func;
    logic [39:0] global_pos;
    logic [31:0] offset;
    logic [31:0] seg_bases;
    logic [15:0] seg_header_bytes;
    logic [15:0] seg_line_width;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  segment_id;
    logic [32:0] pos_in_segment;
    logic [39:0] file_offset;
  } out_word_t;

  typedef struct packed {
    logic [39:0] start;
    logic [31:0] length;
    logic [15:0] header;
    logic [15:0] width;
  } seg_entry_t;

endpackage

// ===== rtl/sequence_position_to_file_offset.sv =====
// Translates a global base position into a segment number, a 1-based position in that
// segment and a byte offset in the segment's line-wrapped text, using a table of up to
// MAX_SEGMENTS segments kept in one synchronous memory. Append, clear and rejected words
// answer without a table search. A translation reads the entry at the remembered cursor
// and moves the cursor one step at a time through the table until the entry holds the
// position, then takes the modulo by the segment length and the division by the line
// width in one shared shift-subtract divider, and finally multiplies and sums the offset.
// One word is in work at a time; a finished result waits in the output register.
module sequence_position_to_file_offset #(
  parameter int MAX_SEGMENTS = 256
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  spos_pkg::in_word_t   in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output spos_pkg::out_word_t  out_data
);

  localparam int IW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int CW = $clog2(MAX_SEGMENTS + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_WAIT, S_CHECK, S_MOD_GO, S_MOD, S_LINE_GO, S_LINE, S_MUL, S_SUM, S_RESP
  } state_t;

  state_t                state_r;
  spos_pkg::in_word_t    req_r;
  spos_pkg::out_word_t   res_r;
  spos_pkg::out_word_t   out_r;
  logic                  out_valid_r;
  logic [CW-1:0]         count_r;
  logic [40:0]           next_start_r;
  logic [IW-1:0]         cursor_r;
  logic [IW-1:0]         cur_r;
  logic [32:0]           sum_r;
  logic [31:0]           pic_r;
  logic [48:0]           prod_r;
  logic [15:0]           rline_r;

  spos_pkg::seg_entry_t  mem [MAX_SEGMENTS];
  spos_pkg::seg_entry_t  rd_data_r;
  logic                  wr_en;

  logic [40:0]           append_sum;
  logic [39:0]           rel;
  logic                  go_down;
  logic                  go_up;
  logic [IW-1:0]         start_cur;
  logic                  div_start;
  logic [32:0]           div_dividend;
  logic [31:0]           div_divisor;
  logic                  div_done;
  logic [32:0]           div_quo;
  logic [31:0]           div_rem;
  logic                  accept;

  assign accept     = in_valid && !in_stall;
  assign in_stall   = state_r != S_IDLE;
  assign append_sum = next_start_r + {9'd0, in_data.seg_bases};
  assign rel        = req_r.global_pos - rd_data_r.start;
  assign go_down    = (cur_r != '0) && (req_r.global_pos < rd_data_r.start);
  assign go_up      = ((CW'(cur_r) + CW'(1)) < count_r) &&
                      ({1'b0, req_r.global_pos} >=
                       ({1'b0, rd_data_r.start} + {9'd0, rd_data_r.length}));
  assign start_cur  = (CW'(cursor_r) >= count_r) ? IW'(count_r - CW'(1)) : cursor_r;

  assign wr_en = accept && (in_data.func == spos_pkg::FN_APPEND) &&
                 (count_r < CW'(MAX_SEGMENTS)) && (in_data.seg_bases != '0) &&
                 (in_data.seg_line_width != '0) && (append_sum <= {1'b1, 40'd0});

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[IW'(count_r)] <= '{start: next_start_r[39:0], length: in_data.seg_bases,
                             header: in_data.seg_header_bytes,
                             width: in_data.seg_line_width};
    end
    rd_data_r <= mem[cur_r];
  end

  assign div_start    = (state_r == S_MOD_GO) || (state_r == S_LINE_GO);
  assign div_dividend = (state_r == S_MOD_GO) ? sum_r : {1'b0, pic_r};
  assign div_divisor  = (state_r == S_MOD_GO) ? rd_data_r.length : {16'd0, rd_data_r.width};

  spos_div #(.DW(33), .VW(32)) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_valid_r  <= 1'b0;
      count_r      <= '0;
      next_start_r <= '0;
      cursor_r     <= '0;
      cur_r        <= '0;
    end else begin
      if (out_valid_r && !out_stall && state_r != S_RESP) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            req_r                <= in_data;
            res_r.segment_id     <= '0;
            res_r.pos_in_segment <= '0;
            res_r.file_offset    <= '0;
            case (in_data.func)
              spos_pkg::FN_APPEND: begin
                state_r <= S_RESP;
                if (count_r >= CW'(MAX_SEGMENTS)) begin
                  res_r.status <= spos_pkg::ST_FULL;
                end else if (in_data.seg_bases == '0 || in_data.seg_line_width == '0) begin
                  res_r.status <= spos_pkg::ST_RANGE;
                end else if (append_sum > {1'b1, 40'd0}) begin
                  res_r.status <= spos_pkg::ST_FULL;
                end else begin
                  res_r.status <= spos_pkg::ST_DONE;
                  count_r      <= count_r + CW'(1);
                  next_start_r <= append_sum;
                end
              end
              spos_pkg::FN_XLATE: begin
                if (count_r == '0 || {1'b0, in_data.global_pos} >= next_start_r) begin
                  res_r.status <= spos_pkg::ST_RANGE;
                  state_r      <= S_RESP;
                end else begin
                  cur_r   <= start_cur;
                  state_r <= S_WAIT;
                end
              end
              spos_pkg::FN_CLEAR: begin
                res_r.status <= spos_pkg::ST_DONE;
                count_r      <= '0;
                next_start_r <= '0;
                cursor_r     <= '0;
                state_r      <= S_RESP;
              end
              default: begin
                res_r.status <= spos_pkg::ST_RANGE;
                state_r      <= S_RESP;
              end
            endcase
          end
        end
        S_WAIT: begin
          state_r <= S_CHECK;
        end
        S_CHECK: begin
          if (go_down) begin
            cur_r   <= cur_r - IW'(1);
            state_r <= S_WAIT;
          end else if (go_up) begin
            cur_r   <= cur_r + IW'(1);
            state_r <= S_WAIT;
          end else begin
            cursor_r                  <= cur_r;
            res_r.status              <= spos_pkg::ST_XLATED;
            res_r.segment_id          <= 8'(cur_r);
            res_r.pos_in_segment      <= {1'b0, rel[31:0]} + 33'd1;
            sum_r                     <= {1'b0, rel[31:0]} + {1'b0, req_r.offset};
            state_r                   <= S_MOD_GO;
          end
        end
        S_MOD_GO: begin
          state_r <= S_MOD;
        end
        S_MOD: begin
          if (div_done) begin
            pic_r   <= div_rem;
            state_r <= S_LINE_GO;
          end
        end
        S_LINE_GO: begin
          state_r <= S_LINE;
        end
        S_LINE: begin
          if (div_done) begin
            rline_r <= div_rem[15:0];
            prod_r  <= div_quo[31:0] * ({1'b0, rd_data_r.width} + 17'd1);
            state_r <= S_MUL;
          end
        end
        S_MUL: begin
          state_r <= S_SUM;
        end
        S_SUM: begin
          res_r.file_offset <= {24'd0, rd_data_r.header} + prod_r[39:0] + {24'd0, rline_r};
          state_r           <= S_RESP;
        end
        S_RESP: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r <= 1'b1;
            out_r       <= res_r;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ===== rtl/spos_div.sv =====
module spos_div #(
  parameter int DW = 33,
  parameter int VW = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic          done,
  output logic [DW-1:0] quotient,
  output logic [VW-1:0] remainder
);

  localparam int CW = $clog2(DW + 1);

  logic [DW-1:0] quo_r;
  logic [VW-1:0] rem_r;
  logic [VW-1:0] div_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic          done_r;
  logic [VW:0]   trial;
  logic          ge;

  assign trial = {rem_r, quo_r[DW-1]};
  assign ge    = trial >= {1'b0, div_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(DW);
        quo_r  <= dividend;
        rem_r  <= '0;
        div_r  <= divisor;
      end else if (busy_r) begin
        rem_r <= ge ? VW'(trial - {1'b0, div_r}) : trial[VW-1:0];
        quo_r <= {quo_r[DW-2:0], ge};
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

// ===== rtl/spos_chk.sv =====
module spos_chk (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input spos_pkg::out_word_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result word changed");

  a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != spos_pkg::ST_XLATED |->
      out_data.segment_id == '0 && out_data.pos_in_segment == '0 &&
      out_data.file_offset == '0)
    else $error("non-translation result carries nonzero fields");

  a_pos_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == spos_pkg::ST_XLATED |-> out_data.pos_in_segment != '0)
    else $error("translated position is zero");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second word taken while one is in work");

endmodule

bind sequence_position_to_file_offset spos_chk u_spos_chk (.*);
